>>> sv/rcci_pkg.sv
// ----------------------------------------------------------------------------
// rcci_pkg
// Shared types and constants for the ray / capped cylinder intersection pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package rcci_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_AXIS        = 2'd0;
  localparam logic [1:0] CFG_HALF_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS      = 2'd2;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Surface codes
  localparam logic [1:0] SURF_SIDE   = 2'd0;
  localparam logic [1:0] SURF_TOP    = 2'd1;
  localparam logic [1:0] SURF_BOTTOM = 2'd2;

  // Q16.16 constants
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE_Q16 = 32'hffff_0000;
  localparam logic [31:0] SAT_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN     = 32'h8000_0000;

  // Pipeline geometry
  localparam int SQRT_STEPS = 64;
  localparam int DIV_STEPS  = 31;
  localparam int LANES      = 4;

  // Divider lanes
  localparam int LANE_NEAR   = 0;
  localparam int LANE_FAR    = 1;
  localparam int LANE_TOP    = 2;
  localparam int LANE_BOTTOM = 3;

  // Per-ray context that travels down the pipe
  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
    logic [63:0]      a;
    logic [63:0]      bm;
    logic             bneg;
    logic             nohit;
    logic             case_both;
    logic             case_far;
    logic [32:0]      mtop;
    logic [32:0]      mbot;
    logic             qneg_top;
    logic             qneg_bot;
    logic [31:0]      dabs;
  } ctx_t;

  // One restoring-divider lane
  typedef struct packed {
    logic [63:0] dv;
    logic [63:0] rem;
    logic [30:0] low;
    logic [30:0] q;
    logic        sat;
    logic        neg;
  } lane_t;

endpackage

`default_nettype wire

>>> sv/ray_capped_cylinder_intersect.sv
// ----------------------------------------------------------------------------
// ray_capped_cylinder_intersect
// Fixed-point ray against capped cylinder: quadratic, exact square root,
// root and cap divisions, hit point, surface and normal. Fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while m_axis does not stall; the 64-stage
// bit-per-stage square root and the 31-stage restoring dividers set the depth.
// The whole pipe advances together and holds while a result waits on m_axis.
// Reset clears all valid bits and loads axis y, half height 0.5, radius 0.5.
`default_nettype none

module ray_capped_cylinder_intersect (
  input  wire logic         clk,
  input  wire logic         rst,
  // slave tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 each)
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [191:0] s_axis_tdata,
  // master tdata: hit_t, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (32 each)
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [223:0]      m_axis_tdata,
  // master tuser: hit (1), surface (2)
  output logic [2:0]        m_axis_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int SQ = rcci_pkg::SQRT_STEPS;
  localparam int DS = rcci_pkg::DIV_STEPS;
  localparam int NL = rcci_pkg::LANES;

  logic [1:0]  axis_select;
  logic [30:0] half_height;
  logic [30:0] cyl_radius;
  logic [1:0]  ax;
  logic        en;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_select <= rcci_pkg::AXIS_Y;
      half_height <= 31'd32768;
      cyl_radius  <= 31'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        rcci_pkg::CFG_AXIS:        axis_select <= cfg_data[1:0];
        rcci_pkg::CFG_HALF_HEIGHT: half_height <= cfg_data[30:0];
        rcci_pkg::CFG_RADIUS:      cyl_radius  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign ax = (axis_select == rcci_pkg::AXIS_X || axis_select == rcci_pkg::AXIS_Y) ?
              axis_select : rcci_pkg::AXIS_Z;

  // Whole pipe moves when the output slot is free or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: select cross-axis coordinates, first products, cap numerators
  // --------------------------------------------------------------------------
  logic [2:0][31:0]   in_o, in_d;
  logic [1:0]         iu, iv;
  logic signed [31:0] ou, ov, du, dv, oa, da;
  logic signed [33:0] nt, nb, hh34;
  rcci_pkg::ctx_t     s1_ctx_next;

  always_comb begin
    in_o = s_axis_tdata[95:0];
    in_d = s_axis_tdata[191:96];
    case (ax)
      rcci_pkg::AXIS_X: begin iu = 2'd1; iv = 2'd2; end
      rcci_pkg::AXIS_Y: begin iu = 2'd2; iv = 2'd0; end
      default:          begin iu = 2'd0; iv = 2'd1; end
    endcase
    ou = in_o[iu];
    ov = in_o[iv];
    du = in_d[iu];
    dv = in_d[iv];
    oa = in_o[ax];
    da = in_d[ax];
    hh34 = {3'b000, half_height};
    nt = hh34 - {{2{oa[31]}}, oa};
    nb = -hh34 - {{2{oa[31]}}, oa};
    s1_ctx_next           = '0;
    s1_ctx_next.o         = in_o;
    s1_ctx_next.d         = in_d;
    s1_ctx_next.mtop      = nt[33] ? 33'(-nt) : nt[32:0];
    s1_ctx_next.mbot      = nb[33] ? 33'(-nb) : nb[32:0];
    s1_ctx_next.qneg_top  = nt[33] ^ da[31];
    s1_ctx_next.qneg_bot  = nb[33] ^ da[31];
    s1_ctx_next.dabs      = da[31] ? 32'(-da) : da;
  end

  logic               s1_v;
  rcci_pkg::ctx_t     s1_ctx;
  logic signed [63:0] s1_pdu, s1_pdv, s1_pbu, s1_pbv, s1_pou, s1_pov;
  logic [61:0]        s1_prr;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= s_axis_tvalid;
    if (en) begin
      s1_ctx <= s1_ctx_next;
      s1_pdu <= du * du;
      s1_pdv <= dv * dv;
      s1_pbu <= du * ou;
      s1_pbv <= dv * ov;
      s1_pou <= ou * ou;
      s1_pov <= ov * ov;
      s1_prr <= cyl_radius * cyl_radius;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: A, |B| with sign, |C| with sign
  // --------------------------------------------------------------------------
  logic [64:0]    bsum, bneg_v;
  logic [63:0]    pm, rm, a_n;
  rcci_pkg::ctx_t s2_ctx_next;

  always_comb begin
    a_n    = s1_pdu + s1_pdv;
    bsum   = {s1_pbu[63], s1_pbu} + {s1_pbv[63], s1_pbv};
    bneg_v = -bsum;
    pm     = s1_pou + s1_pov;
    rm     = {2'b00, s1_prr};
    s2_ctx_next       = s1_ctx;
    s2_ctx_next.a     = a_n;
    s2_ctx_next.bneg  = bsum[64];
    s2_ctx_next.bm    = bsum[64] ? bneg_v[63:0] : bsum[63:0];
    s2_ctx_next.nohit = (a_n == 64'd0);
  end

  logic           s2_v, s2_cneg;
  rcci_pkg::ctx_t s2_ctx;
  logic [63:0]    s2_cm;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
    if (en) begin
      s2_ctx  <= s2_ctx_next;
      s2_cneg <= pm < rm;
      s2_cm   <= (pm < rm) ? rm - pm : pm - rm;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: 32x32 partial products of B*B and A*C
  // --------------------------------------------------------------------------
  logic           s3_v, s3_cneg;
  rcci_pkg::ctx_t s3_ctx;
  logic [63:0]    s3_bb00, s3_bb01, s3_bb11, s3_ac00, s3_ac01, s3_ac10, s3_ac11;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
    if (en) begin
      s3_ctx  <= s2_ctx;
      s3_cneg <= s2_cneg;
      s3_bb00 <= s2_ctx.bm[31:0]  * s2_ctx.bm[31:0];
      s3_bb01 <= s2_ctx.bm[31:0]  * s2_ctx.bm[63:32];
      s3_bb11 <= s2_ctx.bm[63:32] * s2_ctx.bm[63:32];
      s3_ac00 <= s2_ctx.a[31:0]   * s2_cm[31:0];
      s3_ac01 <= s2_ctx.a[31:0]   * s2_cm[63:32];
      s3_ac10 <= s2_ctx.a[63:32]  * s2_cm[31:0];
      s3_ac11 <= s2_ctx.a[63:32]  * s2_cm[63:32];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: assemble B*B and A*C
  // --------------------------------------------------------------------------
  logic           s4_v, s4_cneg;
  rcci_pkg::ctx_t s4_ctx;
  logic [127:0]   s4_bb, s4_ac;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
    if (en) begin
      s4_ctx  <= s3_ctx;
      s4_cneg <= s3_cneg;
      s4_bb   <= {s3_bb11, 64'd0} + ({64'd0, s3_bb01} << 33) + {64'd0, s3_bb00};
      s4_ac   <= {s3_ac11, 64'd0} + (({64'd0, s3_ac01} + {64'd0, s3_ac10}) << 32)
                 + {64'd0, s3_ac00};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: discriminant; reject when negative
  // --------------------------------------------------------------------------
  logic [128:0]   ddiff;
  rcci_pkg::ctx_t s5_ctx_next;

  always_comb begin
    ddiff       = {1'b0, s4_bb} - {1'b0, s4_ac};
    s5_ctx_next = s4_ctx;
    s5_ctx_next.nohit = s4_ctx.nohit || (!s4_cneg && ddiff[128]);
  end

  logic           sq_v    [0:SQ];
  rcci_pkg::ctx_t sq_ctx  [0:SQ];
  logic [127:0]   sq_x    [0:SQ];
  logic [65:0]    sq_rem  [0:SQ];
  logic [63:0]    sq_root [0:SQ];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= s4_v;
    if (en) begin
      sq_ctx[0]  <= s5_ctx_next;
      sq_x[0]    <= s4_cneg ? s4_bb + s4_ac : ddiff[127:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one result bit per stage, restoring remainder form
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [67:0] sh, tr, df;
    logic        ge;
    assign sh = {sq_rem[k], sq_x[k][127:126]};
    assign tr = {2'b00, sq_root[k], 2'b01};
    assign df = sh - tr;
    assign ge = sh >= tr;
    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (en) sq_v[k+1] <= sq_v[k];
      if (en) begin
        sq_ctx[k+1]  <= sq_ctx[k];
        sq_rem[k+1]  <= ge ? df[65:0] : sh[65:0];
        sq_root[k+1] <= {sq_root[k][62:0], ge};
        sq_x[k+1]    <= {sq_x[k][125:0], 2'b00};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Root numerators and case selection
  // --------------------------------------------------------------------------
  logic [63:0]    sroot, bmag;
  rcci_pkg::ctx_t rn_ctx_next;

  always_comb begin
    sroot       = sq_root[SQ];
    bmag        = sq_ctx[SQ].bm;
    rn_ctx_next = sq_ctx[SQ];
    rn_ctx_next.case_both = !sq_ctx[SQ].nohit && sq_ctx[SQ].bneg && (bmag > sroot);
    rn_ctx_next.case_far  = !sq_ctx[SQ].nohit &&
                            ((sq_ctx[SQ].bneg && bmag < sroot) ||
                             (!sq_ctx[SQ].bneg && sroot > bmag));
  end

  logic           rn_v;
  rcci_pkg::ctx_t rn_ctx;
  logic [63:0]    rn_nn;
  logic [64:0]    rn_nf;

  always_ff @(posedge clk) begin
    if (rst) rn_v <= 1'b0;
    else if (en) rn_v <= sq_v[SQ];
    if (en) begin
      rn_ctx <= rn_ctx_next;
      rn_nn  <= bmag - sroot;
      rn_nf  <= sq_ctx[SQ].bneg ? {1'b0, bmag} + {1'b0, sroot} : {1'b0, sroot} - {1'b0, bmag};
    end
  end

  // --------------------------------------------------------------------------
  // Divider setup: numerator * 65536 over divisor, 31 quotient bits
  // --------------------------------------------------------------------------
  function automatic rcci_pkg::lane_t div_init(input logic [65:0] n, input logic [63:0] dvs,
                                               input logic neg);
    rcci_pkg::lane_t l;
    logic [63:0]     r0;
    r0    = {13'd0, n[65:15]};
    l.dv  = dvs;
    l.rem = r0;
    l.low = {n[14:0], 16'd0};
    l.q   = '0;
    l.sat = r0 >= dvs;
    l.neg = neg;
    return l;
  endfunction

  function automatic logic [31:0] lane_val(input rcci_pkg::lane_t l);
    logic [31:0] qv;
    qv = {1'b0, l.q};
    if (l.sat) return l.neg ? rcci_pkg::SAT_MIN : rcci_pkg::SAT_MAX;
    return l.neg ? -qv : qv;
  endfunction

  function automatic logic [31:0] sat32(input logic [49:0] x);
    if ((&x[49:31]) || !(|x[49:31])) return x[31:0];
    return x[49] ? rcci_pkg::SAT_MIN : rcci_pkg::SAT_MAX;
  endfunction

  logic            dv_v    [0:DS];
  rcci_pkg::ctx_t  dv_ctx  [0:DS];
  rcci_pkg::lane_t dv_lane [0:DS][0:NL-1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= rn_v;
    if (en) begin
      dv_ctx[0] <= rn_ctx;
      dv_lane[0][rcci_pkg::LANE_NEAR]   <= div_init({2'b00, rn_nn}, rn_ctx.a, 1'b0);
      dv_lane[0][rcci_pkg::LANE_FAR]    <= div_init({1'b0, rn_nf}, rn_ctx.a, 1'b0);
      dv_lane[0][rcci_pkg::LANE_TOP]    <= div_init({33'd0, rn_ctx.mtop},
                                                    {32'd0, rn_ctx.dabs}, rn_ctx.qneg_top);
      dv_lane[0][rcci_pkg::LANE_BOTTOM] <= div_init({33'd0, rn_ctx.mbot},
                                                    {32'd0, rn_ctx.dabs}, rn_ctx.qneg_bot);
    end
  end

  // Restoring division: one quotient bit per stage in every lane
  for (genvar k = 0; k < DS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (en) dv_v[k+1] <= dv_v[k];
      if (en) dv_ctx[k+1] <= dv_ctx[k];
    end
    for (genvar j = 0; j < NL; j++) begin : g_lane
      logic [64:0]     sh, df;
      logic            ge;
      rcci_pkg::lane_t cur;
      assign cur = dv_lane[k][j];
      assign sh  = {cur.rem, cur.low[30]};
      assign df  = sh - {1'b0, cur.dv};
      assign ge  = sh >= {1'b0, cur.dv};
      always_ff @(posedge clk) begin
        if (en) begin
          dv_lane[k+1][j].dv  <= cur.dv;
          dv_lane[k+1][j].rem <= ge ? df[63:0] : sh[63:0];
          dv_lane[k+1][j].low <= {cur.low[29:0], 1'b0};
          dv_lane[k+1][j].q   <= {cur.q[29:0], ge};
          dv_lane[k+1][j].sat <= cur.sat;
          dv_lane[k+1][j].neg <= cur.neg;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // M1: side root times direction
  // --------------------------------------------------------------------------
  logic signed [31:0] tn_s, tf_s, ts_s, dax_s;
  logic signed [31:0] dcomp [3];
  logic signed [63:0] ps_n  [3];

  always_comb begin
    tn_s  = lane_val(dv_lane[DS][rcci_pkg::LANE_NEAR]);
    tf_s  = lane_val(dv_lane[DS][rcci_pkg::LANE_FAR]);
    ts_s  = dv_ctx[DS].case_both ? tn_s : tf_s;
    dax_s = dv_ctx[DS].d[ax];
    for (int i = 0; i < 3; i++) begin
      dcomp[i] = dv_ctx[DS].d[i];
      ps_n[i]  = ts_s * dcomp[i];
    end
  end

  logic           m1_v;
  rcci_pkg::ctx_t m1_ctx;
  logic [63:0]    m1_ps [3];
  logic [63:0]    m1_pf;
  logic [31:0]    m1_ts, m1_tt, m1_tb;

  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else if (en) m1_v <= dv_v[DS];
    if (en) begin
      m1_ctx <= dv_ctx[DS];
      for (int i = 0; i < 3; i++) m1_ps[i] <= ps_n[i];
      m1_pf  <= tf_s * dax_s;
      m1_ts  <= ts_s;
      m1_tt  <= lane_val(dv_lane[DS][rcci_pkg::LANE_TOP]);
      m1_tb  <= lane_val(dv_lane[DS][rcci_pkg::LANE_BOTTOM]);
    end
  end

  // --------------------------------------------------------------------------
  // R1: hit points O + floor(t*D / 65536)
  // --------------------------------------------------------------------------
  logic           r1_v;
  rcci_pkg::ctx_t r1_ctx;
  logic [49:0]    r1_raw [3];
  logic [49:0]    r1_raw2;
  logic [31:0]    r1_ts, r1_tt, r1_tb;

  always_ff @(posedge clk) begin
    if (rst) r1_v <= 1'b0;
    else if (en) r1_v <= m1_v;
    if (en) begin
      r1_ctx <= m1_ctx;
      for (int i = 0; i < 3; i++) begin
        r1_raw[i] <= {{18{m1_ctx.o[i][31]}}, m1_ctx.o[i]} +
                     {{2{m1_ps[i][63]}}, m1_ps[i][63:16]};
      end
      r1_raw2 <= {{18{m1_ctx.o[ax][31]}}, m1_ctx.o[ax]} + {{2{m1_pf[63]}}, m1_pf[63:16]};
      r1_ts   <= m1_ts;
      r1_tt   <= m1_tt;
      r1_tb   <= m1_tb;
    end
  end

  // --------------------------------------------------------------------------
  // Decide: side, top cap, bottom cap or miss
  // --------------------------------------------------------------------------
  logic signed [49:0] hh_s, nhh_s, rax_s, rf_s;
  logic               in_band, dz, dc_hit_n;
  logic [1:0]         dc_surf_n;
  logic [31:0]        dc_t_n;

  always_comb begin
    hh_s      = {19'd0, half_height};
    nhh_s     = -hh_s;
    rax_s     = r1_raw[ax];
    rf_s      = r1_raw2;
    in_band   = (rax_s >= nhh_s) && (rax_s <= hh_s);
    dz        = (r1_ctx.dabs == 32'd0);
    dc_hit_n  = 1'b0;
    dc_surf_n = rcci_pkg::SURF_SIDE;
    dc_t_n    = r1_ts;
    if (r1_ctx.case_both) begin
      if (in_band) begin
        dc_hit_n = 1'b1;
      end else if (rax_s > hh_s && rf_s <= hh_s) begin
        dc_hit_n  = !dz;
        dc_surf_n = rcci_pkg::SURF_TOP;
        dc_t_n    = r1_tt;
      end else if (rax_s < nhh_s && rf_s >= nhh_s) begin
        dc_hit_n  = !dz;
        dc_surf_n = rcci_pkg::SURF_BOTTOM;
        dc_t_n    = r1_tb;
      end
    end else if (r1_ctx.case_far) begin
      dc_hit_n = in_band;
    end
  end

  logic           dc_v, dc_hit;
  rcci_pkg::ctx_t dc_ctx;
  logic [1:0]     dc_surf;
  logic [31:0]    dc_t;
  logic [49:0]    dc_raw [3];

  always_ff @(posedge clk) begin
    if (rst) dc_v <= 1'b0;
    else if (en) dc_v <= r1_v;
    if (en) begin
      dc_ctx  <= r1_ctx;
      dc_hit  <= dc_hit_n;
      dc_surf <= dc_surf_n;
      dc_t    <= dc_t_n;
      for (int i = 0; i < 3; i++) dc_raw[i] <= r1_raw[i];
    end
  end

  // --------------------------------------------------------------------------
  // M2: cap root times direction
  // --------------------------------------------------------------------------
  logic signed [31:0] tc_s;
  logic signed [31:0] dc_d [3];
  logic signed [63:0] pc_n [3];

  always_comb begin
    tc_s = dc_t;
    for (int i = 0; i < 3; i++) begin
      dc_d[i] = dc_ctx.d[i];
      pc_n[i] = tc_s * dc_d[i];
    end
  end

  logic           m2_v, m2_hit;
  rcci_pkg::ctx_t m2_ctx;
  logic [1:0]     m2_surf;
  logic [31:0]    m2_t;
  logic [49:0]    m2_raw [3];
  logic [63:0]    m2_pc  [3];

  always_ff @(posedge clk) begin
    if (rst) m2_v <= 1'b0;
    else if (en) m2_v <= dc_v;
    if (en) begin
      m2_ctx  <= dc_ctx;
      m2_hit  <= dc_hit;
      m2_surf <= dc_surf;
      m2_t    <= dc_t;
      for (int i = 0; i < 3; i++) begin
        m2_raw[i] <= dc_raw[i];
        m2_pc[i]  <= pc_n[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final: point, saturation, normal, output register
  // --------------------------------------------------------------------------
  logic [49:0]      rawc, rawf;
  logic [2:0][31:0] pos_n, norm_n;
  logic [31:0]      t_n;
  logic [2:0]       user_n;

  always_comb begin
    rawc   = '0;
    rawf   = '0;
    pos_n  = '0;
    norm_n = '0;
    t_n    = '0;
    user_n = '0;
    if (m2_hit) begin
      t_n    = m2_t;
      user_n = {m2_surf, 1'b1};
      for (int i = 0; i < 3; i++) begin
        rawc = {{18{m2_ctx.o[i][31]}}, m2_ctx.o[i]} + {{2{m2_pc[i][63]}}, m2_pc[i][63:16]};
        rawf = (m2_surf == rcci_pkg::SURF_SIDE) ? m2_raw[i] : rawc;
        pos_n[i] = sat32(rawf);
        if (m2_surf == rcci_pkg::SURF_SIDE) begin
          norm_n[i] = (2'(i) == ax) ? 32'd0 : pos_n[i];
        end else if (m2_surf == rcci_pkg::SURF_TOP) begin
          norm_n[i] = (2'(i) == ax) ? rcci_pkg::ONE_Q16 : 32'd0;
        end else begin
          norm_n[i] = (2'(i) == ax) ? rcci_pkg::NEG_ONE_Q16 : 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= m2_v;
    if (en) begin
      m_axis_tdata <= {norm_n, pos_n, t_n};
      m_axis_tuser <= user_n;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && m_axis_tuser == '0)
    else $error("miss result carries nonzero fields");

  a_side_t_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[2:1] == rcci_pkg::SURF_SIDE
    |-> !m_axis_tdata[31])
    else $error("side hit with negative t");

  a_surf_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
    m_axis_tuser[2:1] == rcci_pkg::SURF_SIDE || m_axis_tuser[2:1] == rcci_pkg::SURF_TOP ||
    m_axis_tuser[2:1] == rcci_pkg::SURF_BOTTOM)
    else $error("hit with unknown surface code");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_v[DS] && dv_ctx[DS].case_both && !dv_lane[DS][rcci_pkg::LANE_NEAR].sat
    |-> dv_lane[DS][rcci_pkg::LANE_NEAR].rem < dv_lane[DS][rcci_pkg::LANE_NEAR].dv)
    else $error("near root divider remainder out of range");

endmodule

`default_nettype wire

>>> bench/ray_capped_cylinder_intersect_test.sv
// ----------------------------------------------------------------------------
// ray_capped_cylinder_intersect_test
// Self-checking bench for the ray / capped cylinder pipe. Rays are streamed
// in with random gaps and output stalls, and a bit-exact predictor computes
// each expected hit record. Every result is checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_capped_cylinder_intersect_test;

  typedef struct {
    logic [31:0] o [3];
    logic [31:0] d [3];
  } ray_t;

  typedef struct {
    logic        hit;
    logic [1:0]  surf;
    logic [31:0] f [7];   // hit_t, pos xyz, norm xyz
  } hit_rec_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // Shadow registers of the block
  logic [1:0]  axis_reg;
  logic [30:0] hh_reg;
  logic [30:0] rad_reg;

  hit_rec_t expected_hits [$];
  int       fail_count = 0;
  bit       no_gaps = 1'b0;
  int       hold_cycles = 0;

  ray_capped_cylinder_intersect DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // positive numerator over a, Q16.16, saturated high
  function automatic longint root_time(logic [127:0] n, logic [127:0] a);
    logic [127:0] num;
    num = n << 16;
    if (num >= (a << 31)) return 64'sd2147483647;
    return longint'(num / a);
  endfunction

  function automatic void point_on_ray(longint o [3], longint d [3], longint t,
                                       output longint pt [3]);
    for (int i = 0; i < 3; i++) pt[i] = o[i] + ((t * d[i]) >>> 16);
  endfunction

  function automatic hit_rec_t make_hit(logic [1:0] surf, longint t, longint pt [3],
                                        int ax);
    hit_rec_t r;
    longint p;
    r.hit = 1'b1;
    r.surf = surf;
    r.f[0] = 32'(sat32(t));
    for (int i = 0; i < 3; i++) begin
      p = sat32(pt[i]);
      r.f[1 + i] = 32'(p);
      if (surf == rcci_pkg::SURF_SIDE) r.f[4 + i] = (i == ax) ? 32'd0 : p[31:0];
      else if (i != ax) r.f[4 + i] = 32'd0;
      else r.f[4 + i] = (surf == rcci_pkg::SURF_TOP) ? rcci_pkg::ONE_Q16
                                                     : rcci_pkg::NEG_ONE_Q16;
    end
    return r;
  endfunction

  function automatic hit_rec_t predict_hit(ray_t ray);
    hit_rec_t miss;
    longint o [3], d [3], pn [3], pf [3];
    longint p, q, hh, tn, tf, tc;
    logic signed [65:0] ps, qs, bsum;
    logic [127:0] a, bm, pm, rm, cm, bb, ac, disc, s, c, nn, nf;
    logic bneg, cneg;
    int ax, u, v;
    miss.hit = 1'b0;
    miss.surf = rcci_pkg::SURF_SIDE;
    foreach (miss.f[i]) miss.f[i] = '0;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(signed'(ray.o[i]));
      d[i] = longint'(signed'(ray.d[i]));
    end
    ax = (axis_reg >= rcci_pkg::AXIS_Z) ? 2 : int'(axis_reg);
    u = (ax + 1) % 3;
    v = (ax + 2) % 3;
    hh = longint'(hh_reg);

    // squares are non-negative; sum them unsigned so 2^63 does not wrap
    a = 128'($unsigned(d[u] * d[u])) + 128'($unsigned(d[v] * d[v]));
    if (a == 0) return miss;
    p = d[u] * o[u];
    q = d[v] * o[v];
    ps = 66'(p);
    qs = 66'(q);
    bsum = ps + qs;
    bneg = bsum < 0;
    bm = bneg ? 128'(-bsum) : 128'(bsum);
    pm = 128'($unsigned(o[u] * o[u])) + 128'($unsigned(o[v] * o[v]));
    rm = 128'(rad_reg) * 128'(rad_reg);
    cneg = pm < rm;
    cm = cneg ? rm - pm : pm - rm;
    bb = bm * bm;
    ac = a * cm;
    if (cneg) disc = bb + ac;
    else if (ac > bb) return miss;
    else disc = bb - ac;
    s = '0;
    for (int b = 63; b >= 0; b--) begin
      c = s | (128'd1 << b);
      if (c * c <= disc) s = c;
    end

    // both roots positive
    if (bneg && bm > s) begin
      nn = bm - s;
      nf = bm + s;
      tn = root_time(nn, a);
      tf = root_time(nf, a);
      point_on_ray(o, d, tn, pn);
      point_on_ray(o, d, tf, pf);
      if (pn[ax] >= -hh && pn[ax] <= hh) return make_hit(rcci_pkg::SURF_SIDE, tn, pn, ax);
      if (pn[ax] > hh && pf[ax] <= hh) begin
        if (d[ax] == 0) return miss;
        tc = sat32(((hh - o[ax]) * 64'sd65536) / d[ax]);
        point_on_ray(o, d, tc, pn);
        return make_hit(rcci_pkg::SURF_TOP, tc, pn, ax);
      end
      if (pn[ax] < -hh && pf[ax] >= -hh) begin
        if (d[ax] == 0) return miss;
        tc = sat32(((-hh - o[ax]) * 64'sd65536) / d[ax]);
        point_on_ray(o, d, tc, pn);
        return make_hit(rcci_pkg::SURF_BOTTOM, tc, pn, ax);
      end
      return miss;
    end
    // roots of opposite sign: far side only
    if ((bneg && bm < s) || (!bneg && s > bm)) begin
      nf = bneg ? bm + s : s - bm;
      tf = root_time(nf, a);
      point_on_ray(o, d, tf, pf);
      if (pf[ax] >= -hh && pf[ax] <= hh) return make_hit(rcci_pkg::SURF_SIDE, tf, pf, ax);
    end
    return miss;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  task automatic send_ray(ray_t ray);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ray.d[2], ray.d[1], ray.d[0], ray.o[2], ray.o[1], ray.o[0]};
    // ready is stable from the falling edge up to the next rising edge
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    expected_hits = {expected_hits, predict_hit(ray)};
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain the pipe, then settle so registers can be written safely
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rcci_pkg::CFG_AXIS:        axis_reg = value[1:0];
      rcci_pkg::CFG_HALF_HEIGHT: hh_reg = value[30:0];
      rcci_pkg::CFG_RADIUS:      rad_reg = value[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] scaled_rand();
    int sh;
    sh = $urandom_range(8, 30);
    return 32'(longint'($urandom_range(0, (1 << sh) - 1)) - longint'(1 << (sh - 1)));
  endfunction

  function automatic ray_t random_ray();
    ray_t ray;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0, 1: begin
          ray.o[i] = $urandom();
          ray.d[i] = $urandom();
        end
        2, 3, 4: begin
          ray.o[i] = scaled_rand();
          ray.d[i] = scaled_rand();
        end
        default: begin
          // aim roughly back at the cylinder
          ray.o[i] = scaled_rand();
          ray.d[i] = -ray.o[i] + (scaled_rand() >>> $urandom_range(2, 8));
        end
      endcase
    end
    if ($urandom_range(0, 15) == 0) ray.d[$urandom_range(0, 2)] = '0;
    return ray;
  endfunction

  function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t ray;
    ray.o[0] = ox; ray.o[1] = oy; ray.o[2] = oz;
    ray.d[0] = dx; ray.d[1] = dy; ray.d[2] = dz;
    return ray;
  endfunction

  // ---------------------------------------------------------------- tests
  localparam int ONE = 65536;
  localparam int MAXI = 32'h7fffffff;
  localparam int MINI = 32'h80000000;

  task automatic test_directed();
    send_ray(mk_ray(0, 0, 0, 0, ONE, 0));           // direction along axis: no divisor
    send_ray(mk_ray(0, 0, 0, 0, 0, 0));             // zero direction
    send_ray(mk_ray(-2 * ONE, 0, 0, ONE, 0, 0));    // side hit from outside
    send_ray(mk_ray(0, 0, 0, ONE, 0, 0));           // from inside, far side
    send_ray(mk_ray(2 * ONE, 0, 0, ONE, 0, 0));     // both roots negative
    send_ray(mk_ray(-2 * ONE, 4 * ONE, 0, ONE, -2 * ONE, 0));  // top cap
    send_ray(mk_ray(-2 * ONE, -4 * ONE, 0, ONE, 2 * ONE, 0));  // bottom cap
    send_ray(mk_ray(-2 * ONE, 4 * ONE, 0, ONE, 0, 0));  // passes over the top
    send_ray(mk_ray(-2 * ONE, ONE / 2, 0, ONE, 0, 0));  // on top edge height
    send_ray(mk_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 0));  // tangent
    send_ray(mk_ray(-2 * ONE, 0, 2 * ONE, ONE, 0, 0));  // miss, negative disc
    send_ray(mk_ray(-ONE / 2, 0, 0, ONE, 0, 0));    // origin on surface
    send_ray(mk_ray(MINI, MINI, MINI, MAXI, MAXI, MAXI));
    send_ray(mk_ray(MAXI, MAXI, MAXI, MINI, MINI, MINI));
    send_ray(mk_ray(MINI, 0, MAXI, MAXI, MINI, MINI));
    send_ray(mk_ray(MAXI, MINI, 0, 1, -1, 1));
    send_ray(mk_ray(-2 * ONE, 0, 0, 1, 0, 0));      // tiny direction, t saturates
    send_ray(mk_ray(-3, 0, 0, MAXI, 0, 0));
    wait_idle();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_ray(random_ray());
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [1:0]  axes [8] = '{rcci_pkg::AXIS_X, rcci_pkg::AXIS_Z, 2'd3, rcci_pkg::AXIS_Y,
                              rcci_pkg::AXIS_X, rcci_pkg::AXIS_Z, rcci_pkg::AXIS_Y, 2'd3};
    logic [31:0] hhs [8] = '{32'd65536, 32'd4096, 32'hffffffff, 32'd0,
                             32'h7fffffff, 32'd1 << 20, 32'd1, 32'd200000};
    logic [31:0] rads [8] = '{32'd131072, 32'd1 << 22, 32'd0, 32'h7fffffff,
                              32'd1, 32'hffffffff, 32'd70000, 32'd1 << 18};
    for (int k = 0; k < 8; k++) begin
      write_reg(rcci_pkg::CFG_AXIS, {$urandom() & 32'hfffffffc} | axes[k]);
      write_reg(rcci_pkg::CFG_HALF_HEIGHT, hhs[k]);
      write_reg(rcci_pkg::CFG_RADIUS, rads[k]);
      if (k == 3) write_reg(2'd3, $urandom());   // index past the list: ignored
      no_gaps = (k == 5);
      test_random(100);
      no_gaps = 1'b0;
    end
  endtask

  // hold the output long enough for the pipe to fill and back up the input
  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_cycles = 400;
    test_random(300);
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------- output side
  initial begin
    int run;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (no_gaps || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        run = $urandom_range(1, 20);
        repeat (run) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        run = pick_gap();
        repeat (run + 1) @(posedge clk);
      end
    end
  end

  // check each accepted result against the oldest prediction
  always @(posedge clk) begin
    hit_rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected item", 32'd0, 32'd0);
      end else begin
        want = expected_hits.pop_front();
        if (m_axis_tuser[0] !== want.hit)
          report_mismatch("hit", 32'(m_axis_tuser[0]), 32'(want.hit));
        if (m_axis_tuser[2:1] !== want.surf)
          report_mismatch("surface", 32'(m_axis_tuser[2:1]), 32'(want.surf));
        for (int i = 0; i < 7; i++)
          if (m_axis_tdata[32 * i +: 32] !== want.f[i])
            report_mismatch($sformatf("field %0d", i), m_axis_tdata[32 * i +: 32],
                            want.f[i]);
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    axis_reg = rcci_pkg::AXIS_Y;
    hh_reg = 31'd32768;
    rad_reg = 31'd32768;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100);
    test_backpressure();
    test_config_sweep();
    wait_idle();
    repeat (150) @(posedge clk);
    if (fail_count == 0 && expected_hits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
sv/rcci_pkg.sv
sv/ray_capped_cylinder_intersect.sv
bench/ray_capped_cylinder_intersect_test.sv
